### rtl/core/ple_pkg.sv
// Shared types and constants for the positional list engine.
`timescale 1ns / 1ps

package ple_pkg;

   localparam int ACT_W = 3;
   localparam int VAL_W = 32;
   localparam int POS_W = 5;
   localparam int ST_W  = 3;

   typedef enum logic [ACT_W-1:0] {
      ACT_INSERT = 3'd0,
      ACT_DELETE = 3'd1,
      ACT_SEARCH = 3'd2,
      ACT_MODIFY = 3'd3,
      ACT_DUMP   = 3'd4
   } action_type;

   typedef enum logic [ST_W-1:0] {
      ST_OK       = 3'd0,
      ST_FULL     = 3'd1,
      ST_EMPTY    = 3'd2,
      ST_BADPOS   = 3'd3,
      ST_NOTFOUND = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      IDX_HOLD   = 3'd0,
      IDX_ZERO   = 3'd1,
      IDX_COUNT  = 3'd2,
      IDX_POS_M1 = 3'd3,
      IDX_INC    = 3'd4,
      IDX_DEC    = 3'd5
   } idx_op_type;

   typedef enum logic [1:0] {
      RD_IDX    = 2'd0,
      RD_IDX_M1 = 2'd1,
      RD_IDX_P1 = 2'd2
   } rd_sel_type;

   typedef enum logic {
      WR_OPERAND = 1'b0,
      WR_READ    = 1'b1
   } wr_sel_type;

   typedef enum logic [1:0] {
      RES_ERR     = 2'd0,
      RES_WRITTEN = 2'd1,
      RES_DELETED = 2'd2,
      RES_DUMP    = 2'd3
   } res_sel_type;

   typedef enum logic [1:0] {
      CNT_HOLD = 2'd0,
      CNT_INC  = 2'd1,
      CNT_DEC  = 2'd2
   } cnt_op_type;

   typedef struct packed {
      logic        load;
      idx_op_type  idx_op;
      logic        rd_en;
      rd_sel_type  rd_sel;
      logic        wr_en;
      wr_sel_type  wr_sel;
      logic        keep;
      cnt_op_type  cnt_op;
      logic        emit;
      res_sel_type res_sel;
      status_type  err_status;
   } cmd_type;

   typedef struct packed {
      logic [ACT_W-1:0] action;
      logic             full;
      logic             empty;
      logic             ins_pos_bad;
      logic             pos_bad;
      logic             idx_above_tgt;
      logic             idx_next_stored;
      logic             idx_last;
      logic             match;
      logic             rsp_free;
   } sts_type;

endpackage

### rtl/core/positional_list_engine_top.sv
// Each input transfer is loaded in S_IDLE and checked in S_CHECK; an error result is then
// registered from S_EMIT_ERR, other results from S_EMIT_VAL, S_EMIT_DEL or S_DUMP_EMIT.
// One item is taken at a time, the next once back in S_IDLE. A shifted entry takes a
// registered read, then a write; a compared or dumped one a read, then a compare or emit.
// Reset is synchronous and clears the count, the controller and the output valid;
// the entry memory is not cleared.
`timescale 1ns / 1ps

module positional_list_engine_top
   import ple_pkg::*;
#(
   parameter int CAPACITY = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [ACT_W-1:0]        req_action,
   input  logic signed [VAL_W-1:0] req_operand_value,
   input  logic [POS_W-1:0]        req_position,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [ST_W-1:0]         rsp_status,
   output logic [POS_W-1:0]        rsp_result_position,
   output logic signed [VAL_W-1:0] rsp_result_value,
   output logic                    rsp_last
);

   cmd_type cmd;
   sts_type sts;

   ple_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   ple_dpath #(
      .CAPACITY (CAPACITY)
   ) u_dpath (
      .clock               (clock),
      .reset               (reset),
      .req_action          (req_action),
      .req_operand_value   (req_operand_value),
      .req_position        (req_position),
      .cmd                 (cmd),
      .sts                 (sts),
      .rsp_stall           (rsp_stall),
      .rsp_valid           (rsp_valid),
      .rsp_status          (rsp_status),
      .rsp_result_position (rsp_result_position),
      .rsp_result_value    (rsp_result_value),
      .rsp_last            (rsp_last)
   );

   // The block stays busy on the cycle after an input transfer.
   a_busy_after_transfer: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input taken while an item is still in progress");

   a_emit_into_free_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> sts.rsp_free)
      else $error("result written over a pending result");

   a_no_growth_when_full: assert property (@(posedge clock) disable iff (reset)
      cmd.cnt_op == CNT_INC |-> !sts.full)
      else $error("entry count grows beyond capacity");

endmodule

### rtl/core/ple_dpath.sv
// Datapath of the positional list engine: entry memory, count, index and result register.
`timescale 1ns / 1ps

module ple_dpath
   import ple_pkg::*;
#(
   parameter int CAPACITY = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [ACT_W-1:0]        req_action,
   input  logic signed [VAL_W-1:0] req_operand_value,
   input  logic [POS_W-1:0]        req_position,
   input  cmd_type                 cmd,
   output sts_type                 sts,
   input  logic                    rsp_stall,
   output logic                    rsp_valid,
   output logic [ST_W-1:0]         rsp_status,
   output logic [POS_W-1:0]        rsp_result_position,
   output logic signed [VAL_W-1:0] rsp_result_value,
   output logic                    rsp_last
);

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

   logic [ACT_W-1:0]        action_ff;
   logic signed [VAL_W-1:0] operand_ff;
   logic [POS_W-1:0]        pos_ff;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [CNT_W-1:0]        idx_ff, idx_in;
   logic signed [VAL_W-1:0] rd_data_ff;
   logic signed [VAL_W-1:0] keep_ff;
   logic [VAL_W-1:0]        mem [CAPACITY];

   logic                    rsp_valid_ff, rsp_valid_in;
   status_type              rsp_status_ff, rsp_status_in;
   logic [POS_W-1:0]        rsp_pos_ff, rsp_pos_in;
   logic signed [VAL_W-1:0] rsp_value_ff, rsp_value_in;
   logic                    rsp_last_ff, rsp_last_in;

   logic [CMP_W-1:0]        pos_ext, count_ext, idx_ext, idx_next, tgt;
   logic [IDX_W-1:0]        rd_addr;
   logic [VAL_W-1:0]        wr_data;

   assign pos_ext   = CMP_W'(pos_ff);
   assign count_ext = CMP_W'(count_ff);
   assign idx_ext   = CMP_W'(idx_ff);
   assign idx_next  = idx_ext + CMP_W'(1);
   assign tgt       = (pos_ext > count_ext) ? count_ext : pos_ext - CMP_W'(1);

   assign sts.action          = action_ff;
   assign sts.full            = (count_ext == CMP_W'(CAPACITY));
   assign sts.empty           = (count_ff == '0);
   assign sts.ins_pos_bad     = (pos_ff == '0) || (pos_ext > CMP_W'(CAPACITY));
   assign sts.pos_bad         = (pos_ff == '0) || (pos_ext > count_ext);
   assign sts.idx_above_tgt   = (idx_ext > tgt);
   assign sts.idx_next_stored = (idx_next < count_ext);
   assign sts.idx_last        = (idx_next == count_ext);
   assign sts.match           = (rd_data_ff == operand_ff);
   assign sts.rsp_free        = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      unique case (cmd.idx_op)
         IDX_HOLD:   idx_in = idx_ff;
         IDX_ZERO:   idx_in = '0;
         IDX_COUNT:  idx_in = count_ff;
         IDX_POS_M1: idx_in = CNT_W'(pos_ext - CMP_W'(1));
         IDX_INC:    idx_in = CNT_W'(idx_next);
         IDX_DEC:    idx_in = idx_ff - CNT_W'(1);
         default:    idx_in = idx_ff;
      endcase
   end

   always_comb begin
      unique case (cmd.rd_sel)
         RD_IDX:    rd_addr = idx_ff[IDX_W-1:0];
         RD_IDX_M1: rd_addr = IDX_W'(idx_ff - CNT_W'(1));
         RD_IDX_P1: rd_addr = IDX_W'(idx_next);
         default:   rd_addr = idx_ff[IDX_W-1:0];
      endcase
   end

   assign wr_data = (cmd.wr_sel == WR_READ) ? rd_data_ff : operand_ff;

   always_comb begin
      unique case (cmd.cnt_op)
         CNT_HOLD: count_in = count_ff;
         CNT_INC:  count_in = count_ff + CNT_W'(1);
         CNT_DEC:  count_in = count_ff - CNT_W'(1);
         default:  count_in = count_ff;
      endcase
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_pos_in    = rsp_pos_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_last_in   = rsp_last_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         unique case (cmd.res_sel)
            RES_ERR: begin
               rsp_status_in = cmd.err_status;
               rsp_pos_in    = '0;
               rsp_value_in  = '0;
               rsp_last_in   = 1'b1;
            end
            RES_WRITTEN: begin
               rsp_status_in = ST_OK;
               rsp_pos_in    = POS_W'(idx_next);
               rsp_value_in  = operand_ff;
               rsp_last_in   = 1'b1;
            end
            RES_DELETED: begin
               rsp_status_in = ST_OK;
               rsp_pos_in    = pos_ff;
               rsp_value_in  = keep_ff;
               rsp_last_in   = 1'b1;
            end
            RES_DUMP: begin
               rsp_status_in = ST_OK;
               rsp_pos_in    = POS_W'(idx_next);
               rsp_value_in  = rd_data_ff;
               rsp_last_in   = sts.idx_last;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff        <= idx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_pos_ff    <= rsp_pos_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_last_ff   <= rsp_last_in;
      if (cmd.load) begin
         action_ff  <= req_action;
         operand_ff <= req_operand_value;
         pos_ff     <= req_position;
      end
      if (cmd.keep) begin
         keep_ff <= rd_data_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[idx_ff[IDX_W-1:0]] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_result_position = rsp_pos_ff;
   assign rsp_result_value    = rsp_value_ff;
   assign rsp_last            = rsp_last_ff;

endmodule

### rtl/core/ple_ctrl.sv
// Controller state machine of the positional list engine.
`timescale 1ns / 1ps

module ple_ctrl
   import ple_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  sts_type sts,
   output cmd_type cmd
);

   typedef enum logic [15:0] {
      S_IDLE      = 16'h0001,
      S_CHECK     = 16'h0002,
      S_INS_RD    = 16'h0004,
      S_INS_WR    = 16'h0008,
      S_MOD_WR    = 16'h0010,
      S_DEL_RD0   = 16'h0020,
      S_DEL_KEEP  = 16'h0040,
      S_DEL_RD    = 16'h0080,
      S_DEL_WR    = 16'h0100,
      S_SRCH_RD   = 16'h0200,
      S_SRCH_CMP  = 16'h0400,
      S_DUMP_RD   = 16'h0800,
      S_DUMP_EMIT = 16'h1000,
      S_EMIT_VAL  = 16'h2000,
      S_EMIT_DEL  = 16'h4000,
      S_EMIT_ERR  = 16'h8000
   } state_type;

   state_type  state_ff, state_in;
   status_type err_ff, err_in;

   assign req_stall = reset || (state_ff != S_IDLE);

   always_comb begin
      cmd            = '0;
      cmd.err_status = err_ff;
      state_in       = state_ff;
      err_in         = err_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && !req_stall) begin
               cmd.load = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            unique case (sts.action)
               ACT_INSERT: begin
                  priority if (sts.full) begin
                     err_in   = ST_FULL;
                     state_in = S_EMIT_ERR;
                  end else if (sts.ins_pos_bad) begin
                     err_in   = ST_BADPOS;
                     state_in = S_EMIT_ERR;
                  end else begin
                     cmd.idx_op = IDX_COUNT;
                     state_in   = S_INS_RD;
                  end
               end
               ACT_DELETE: begin
                  priority if (sts.empty) begin
                     err_in   = ST_EMPTY;
                     state_in = S_EMIT_ERR;
                  end else if (sts.pos_bad) begin
                     err_in   = ST_BADPOS;
                     state_in = S_EMIT_ERR;
                  end else begin
                     cmd.idx_op = IDX_POS_M1;
                     state_in   = S_DEL_RD0;
                  end
               end
               ACT_SEARCH: begin
                  if (sts.empty) begin
                     err_in   = ST_NOTFOUND;
                     state_in = S_EMIT_ERR;
                  end else begin
                     cmd.idx_op = IDX_ZERO;
                     state_in   = S_SRCH_RD;
                  end
               end
               ACT_MODIFY: begin
                  if (sts.pos_bad) begin
                     err_in   = ST_BADPOS;
                     state_in = S_EMIT_ERR;
                  end else begin
                     cmd.idx_op = IDX_POS_M1;
                     state_in   = S_MOD_WR;
                  end
               end
               ACT_DUMP: begin
                  if (sts.empty) begin
                     err_in   = ST_EMPTY;
                     state_in = S_EMIT_ERR;
                  end else begin
                     cmd.idx_op = IDX_ZERO;
                     state_in   = S_DUMP_RD;
                  end
               end
               default: state_in = S_IDLE;
            endcase
         end
         S_INS_RD: begin
            if (sts.idx_above_tgt) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_IDX_M1;
               state_in   = S_INS_WR;
            end else begin
               cmd.wr_en  = 1'b1;
               cmd.wr_sel = WR_OPERAND;
               cmd.cnt_op = CNT_INC;
               state_in   = S_EMIT_VAL;
            end
         end
         S_INS_WR: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = WR_READ;
            cmd.idx_op = IDX_DEC;
            state_in   = S_INS_RD;
         end
         S_MOD_WR: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = WR_OPERAND;
            state_in   = S_EMIT_VAL;
         end
         S_DEL_RD0: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_IDX;
            state_in   = S_DEL_KEEP;
         end
         S_DEL_KEEP: begin
            cmd.keep = 1'b1;
            state_in = S_DEL_RD;
         end
         S_DEL_RD: begin
            if (sts.idx_next_stored) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_IDX_P1;
               state_in   = S_DEL_WR;
            end else begin
               state_in = S_EMIT_DEL;
            end
         end
         S_DEL_WR: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = WR_READ;
            cmd.idx_op = IDX_INC;
            state_in   = S_DEL_RD;
         end
         S_SRCH_RD: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_IDX;
            state_in   = S_SRCH_CMP;
         end
         S_SRCH_CMP: begin
            priority if (sts.match) begin
               state_in = S_EMIT_VAL;
            end else if (sts.idx_next_stored) begin
               cmd.idx_op = IDX_INC;
               state_in   = S_SRCH_RD;
            end else begin
               err_in   = ST_NOTFOUND;
               state_in = S_EMIT_ERR;
            end
         end
         S_DUMP_RD: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_IDX;
            state_in   = S_DUMP_EMIT;
         end
         S_DUMP_EMIT: begin
            if (sts.rsp_free) begin
               cmd.emit    = 1'b1;
               cmd.res_sel = RES_DUMP;
               if (sts.idx_last) begin
                  state_in = S_IDLE;
               end else begin
                  cmd.idx_op = IDX_INC;
                  state_in   = S_DUMP_RD;
               end
            end
         end
         S_EMIT_VAL: begin
            if (sts.rsp_free) begin
               cmd.emit    = 1'b1;
               cmd.res_sel = RES_WRITTEN;
               state_in    = S_IDLE;
            end
         end
         S_EMIT_DEL: begin
            if (sts.rsp_free) begin
               cmd.emit    = 1'b1;
               cmd.res_sel = RES_DELETED;
               cmd.cnt_op  = CNT_DEC;
               state_in    = S_IDLE;
            end
         end
         S_EMIT_ERR: begin
            if (sts.rsp_free) begin
               cmd.emit    = 1'b1;
               cmd.res_sel = RES_ERR;
               state_in    = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      err_ff <= err_in;
   end

endmodule

### bench/positional_list_engine_top_tb.sv
// Self-checking testbench for the positional list engine with a scoreboard list model.
`timescale 1ns / 1ps

module positional_list_engine_top_tb;
   import ple_pkg::*;

   localparam int CAP         = 16;
   localparam int LONG_HOLD   = 150;
   localparam int QUIET_LIMIT = 2000;
   localparam int DRAIN       = 2 * CAP + 40;

   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_stall;
   logic [ACT_W-1:0]        req_action;
   logic signed [VAL_W-1:0] req_operand_value;
   logic [POS_W-1:0]        req_position;
   logic                    rsp_valid;
   logic                    rsp_stall;
   logic [ST_W-1:0]         rsp_status;
   logic [POS_W-1:0]        rsp_result_position;
   logic signed [VAL_W-1:0] rsp_result_value;
   logic                    rsp_last;

   int send_idle_pct;
   int recv_stall_pct;
   bit hold_req;

   typedef struct {
      status_type              status;
      logic [POS_W-1:0]        position;
      logic signed [VAL_W-1:0] value;
      logic                    last;
   } list_reply_type;

   class list_scoreboard;
      logic signed [VAL_W-1:0] slots [CAP];
      int fill;
      list_reply_type awaited [$];
      int mismatches;
      int replies;
      int commands;
      int ignored;
      int full_hits;

      function new();
         fill       = 0;
         mismatches = 0;
         replies    = 0;
         commands   = 0;
         ignored    = 0;
         full_hits  = 0;
      endfunction

      function void push(status_type st, int p, logic signed [VAL_W-1:0] v, logic fin);
         list_reply_type r;
         r.status   = st;
         r.position = p[POS_W-1:0];
         r.value    = v;
         r.last     = fin;
         awaited.push_back(r);
      endfunction

      function void note_request(logic [ACT_W-1:0] act, logic signed [VAL_W-1:0] v,
                                 logic [POS_W-1:0] p);
         int at;
         int idx;
         at = int'(p);
         commands++;
         case (act)
            ACT_INSERT: begin
               if (fill >= CAP) begin
                  push(ST_FULL, 0, 0, 1'b1);
                  full_hits++;
               end else if (at < 1 || at > CAP) begin
                  push(ST_BADPOS, 0, 0, 1'b1);
               end else begin
                  if (at > fill)
                     at = fill + 1;
                  for (idx = fill; idx >= at; idx--)
                     slots[idx] = slots[idx-1];
                  slots[at-1] = v;
                  fill++;
                  push(ST_OK, at, v, 1'b1);
               end
            end
            ACT_DELETE: begin
               if (fill == 0) begin
                  push(ST_EMPTY, 0, 0, 1'b1);
               end else if (at < 1 || at > fill) begin
                  push(ST_BADPOS, 0, 0, 1'b1);
               end else begin
                  push(ST_OK, at, slots[at-1], 1'b1);
                  for (idx = at - 1; idx < fill - 1; idx++)
                     slots[idx] = slots[idx+1];
                  fill--;
               end
            end
            ACT_SEARCH: begin
               at = 0;
               for (idx = fill - 1; idx >= 0; idx--)
                  if (slots[idx] == v)
                     at = idx + 1;
               if (at == 0)
                  push(ST_NOTFOUND, 0, 0, 1'b1);
               else
                  push(ST_OK, at, v, 1'b1);
            end
            ACT_MODIFY: begin
               if (at < 1 || at > fill) begin
                  push(ST_BADPOS, 0, 0, 1'b1);
               end else begin
                  slots[at-1] = v;
                  push(ST_OK, at, v, 1'b1);
               end
            end
            ACT_DUMP: begin
               if (fill == 0)
                  push(ST_EMPTY, 0, 0, 1'b1);
               else
                  for (idx = 0; idx < fill; idx++)
                     push(ST_OK, idx + 1, slots[idx], idx == fill - 1);
            end
            default: begin
               ignored++;
            end
         endcase
      endfunction

      function void check_result(logic [ST_W-1:0] st, logic [POS_W-1:0] p,
                                 logic signed [VAL_W-1:0] v, logic fin);
         list_reply_type want;
         replies++;
         if (awaited.size() == 0) begin
            mismatches++;
            $display("%0t: response with none expected: status %0d position %0d value %0d last %0b",
                     $time, st, p, v, fin);
            return;
         end
         want = awaited.pop_front();
         if (st !== want.status) begin
            mismatches++;
            $display("%0t: status expected %0d actual %0d", $time, want.status, st);
         end
         if (p !== want.position) begin
            mismatches++;
            $display("%0t: position expected %0d actual %0d", $time, want.position, p);
         end
         if (v !== want.value) begin
            mismatches++;
            $display("%0t: value expected %0d actual %0d", $time, want.value, v);
         end
         if (fin !== want.last) begin
            mismatches++;
            $display("%0t: last expected %0b actual %0b", $time, want.last, fin);
         end
      endfunction
   endclass

   list_scoreboard board;

   positional_list_engine_top #(
      .CAPACITY(CAP)
   ) uut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_action          (req_action),
      .req_operand_value   (req_operand_value),
      .req_position        (req_position),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_status          (rsp_status),
      .rsp_result_position (rsp_result_position),
      .rsp_result_value    (rsp_result_value),
      .rsp_last            (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   task automatic send_item(input logic [ACT_W-1:0] act, input logic signed [VAL_W-1:0] v,
                            input logic [POS_W-1:0] p);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_action        <= act;
      req_operand_value <= v;
      req_position      <= p;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      board.note_request(act, v, p);
   endtask

   task automatic send_random(input int n, input bit grow);
      int r;
      logic [ACT_W-1:0] act;
      logic signed [VAL_W-1:0] v;
      logic [POS_W-1:0] p;
      for (int k = 0; k < n; k++) begin
         r = $urandom_range(99);
         if (r < 3)
            act = ACT_W'($urandom_range(7, 5));
         else if (r < (grow ? 45 : 22))
            act = ACT_INSERT;
         else if (r < 62)
            act = ACT_DELETE;
         else if (r < 77)
            act = ACT_SEARCH;
         else if (r < 92)
            act = ACT_MODIFY;
         else
            act = ACT_DUMP;

         r = $urandom_range(99);
         if (act == ACT_SEARCH && board.fill > 0 && r < 60) begin
            v = board.slots[$urandom_range(board.fill - 1)];
         end else if (r < 15) begin
            case ($urandom_range(3))
               0: v = 32'sh7fff_ffff;
               1: v = 32'sh8000_0000;
               2: v = -1;
               default: v = 0;
            endcase
         end else if (r < 40) begin
            v = $urandom_range(3);
         end else begin
            v = $urandom();
         end

         r = $urandom_range(99);
         if (r < 6)
            p = '0;
         else if (r < 14)
            p = POS_W'($urandom_range(31, CAP + 1));
         else if (r < 24)
            p = POS_W'(board.fill);
         else
            p = POS_W'($urandom_range(board.fill + 1, 1));

         send_item(act, v, p);
      end
   endtask

   // The receiver samples each transfer at the edge and then picks its next stall.
   initial begin
      int hold_left;
      bit hold_seen;
      hold_left = 0;
      hold_seen = 1'b0;
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall)
            board.check_result(rsp_status, rsp_result_position, rsp_result_value, rsp_last);
         if (hold_req && !hold_seen) begin
            hold_seen = 1'b1;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_stall_pct);
         end
      end
   end

   initial begin
      int quiet;
      quiet = 0;
      forever begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet = 0;
         else
            quiet++;
         if (quiet >= QUIET_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
            $display("FAIL");
            $finish;
         end
      end
   end

   initial begin
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_action        = '0;
      req_operand_value = '0;
      req_position      = '0;
      send_idle_pct     = 0;
      recv_stall_pct    = 0;
      hold_req          = 1'b0;
      board             = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      send_item(ACT_DELETE, 0, 1);
      send_item(ACT_DUMP, 0, 0);
      send_item(ACT_SEARCH, 0, 0);
      send_item(ACT_MODIFY, 7, 1);
      send_item(ACT_INSERT, 1, 0);
      send_item(ACT_INSERT, 1, 17);
      send_item(ACT_INSERT, 32'sh7fff_ffff, 31);
      send_item(ACT_INSERT, 32'sh7fff_ffff, 9);
      send_item(ACT_INSERT, 32'sh8000_0000, 1);
      send_item(ACT_INSERT, -1, 2);
      send_item(ACT_INSERT, 0, 16);
      send_item(ACT_SEARCH, -1, 0);
      send_item(ACT_MODIFY, 5, 3);
      send_item(ACT_SEARCH, 0, 0);
      send_item(ACT_SEARCH, 32'sh7fff_ffff, 0);
      send_item(ACT_MODIFY, 9, 5);
      send_item(ACT_DELETE, 0, 0);
      send_item(ACT_DELETE, 0, 5);
      send_item(ACT_DELETE, 0, 4);
      // The removed value still sits in memory past the count and must not be found.
      send_item(ACT_SEARCH, 0, 0);
      send_item(3'd5, 11, 1);
      send_item(3'd7, 11, 2);
      send_item(ACT_DUMP, 0, 0);
      send_item(ACT_DELETE, 0, 1);

      send_idle_pct = 49;
      send_random(40, 1'b1);
      send_idle_pct  = 0;
      recv_stall_pct = 49;
      send_random(40, 1'b0);
      send_idle_pct  = 12;
      recv_stall_pct = 12;
      send_random(40, 1'b1);
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      send_random(30, 1'b0);

      // Fill the list to capacity while the output is held off, then dump it.
      hold_req = 1'b1;
      repeat (CAP + 2)
         send_item(ACT_INSERT, $urandom(), POS_W'($urandom_range(CAP, 1)));
      send_item(ACT_DUMP, 0, 0);
      send_item(ACT_MODIFY, 32'sh8000_0000, CAP);
      send_item(ACT_DELETE, 0, CAP);
      send_random(15, 1'b0);
      req_valid <= 1'b0;

      while (board.awaited.size() != 0)
         @(posedge clock);
      repeat (DRAIN) @(posedge clock);

      $display("Summary: %0d commands sent (%0d with unused codes), %0d responses checked,",
               board.commands, board.ignored, board.replies);
      $display("list found full %0d times, %0d mismatches over four idle mixes and a long hold.",
               board.full_hits, board.mismatches);
      if (board.mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

### files.f
rtl/core/ple_pkg.sv
rtl/core/ple_dpath.sv
rtl/core/ple_ctrl.sv
rtl/core/positional_list_engine_top.sv
bench/positional_list_engine_top_tb.sv
